// ===== rtl/ssr_pkg.sv =====
// Shared widths and the series snapshot type for the Sharpe/Sortino ratio unit.
`default_nettype none
package ssr_pkg;
  localparam int CNT_W   = 17;   // series and downside counts
  localparam int RET_W   = 24;   // Q4.20 return and rate
  localparam int EXC_W   = 25;   // excess return, one bit wider than a return
  localparam int MAG_IN_W = 24;  // magnitude of an excess return
  localparam int SQ_W    = 48;   // square of one excess return
  localparam int SUM_W   = 41;   // saturating excess sum
  localparam int SQS_W   = 64;   // saturating square sums
  localparam int RATIO_W = 32;   // Q16.16 result
  localparam int MUL_W   = 128;  // serial multiplier accumulator
  localparam int MULT_W  = 41;   // serial multiplier operand
  localparam int S2_W    = 81;   // squared excess sum and same-size products
  localparam int DEN_W   = 100;  // divisor of the ratio
  localparam int FRAC_W  = 32;   // scale of the dividend
  localparam int NUM_W   = DEN_W + FRAC_W;
  localparam int QUO_W   = 62;   // quotient bits kept below the saturation bit
  localparam int DSH_W   = DEN_W + QUO_W;
  localparam int ROOT_W  = 64;
  localparam int MAG_W   = 31;

  // Totals of one finished series, handed from the front to the back.
  typedef struct packed {
    logic [CNT_W-1:0]        cnt;
    logic signed [SUM_W-1:0] esum;
    logic [SQS_W-1:0]        qsum;
    logic [SQS_W-1:0]        qdsum;
    logic [CNT_W-1:0]        kcnt;
  } snap_t;
endpackage
`default_nettype wire

// ===== rtl/ssr_front.sv =====
// Front end: forms excess returns and keeps the running series sums.
`default_nettype none
module ssr_front #(
  parameter int MAX_SERIES = 65536
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               accept,
  input  wire logic signed [ssr_pkg::RET_W-1:0]   period_return,
  input  wire logic                               last_return,
  input  wire logic signed [ssr_pkg::RET_W-1:0]   risk_free_rate,
  output logic                                    push,
  output ssr_pkg::snap_t                          snap
);
  logic signed [ssr_pkg::EXC_W-1:0]  e_in;
  logic [ssr_pkg::EXC_W-1:0]         e_abs;
  logic [ssr_pkg::SQ_W-1:0]          sq_in;
  logic                              a_valid;
  logic                              a_last;
  logic signed [ssr_pkg::EXC_W-1:0]  a_e;
  logic [ssr_pkg::SQ_W-1:0]          a_sq;
  logic [ssr_pkg::CNT_W-1:0]         cnt, kcnt;
  logic signed [ssr_pkg::SUM_W-1:0]  esum;
  logic [ssr_pkg::SQS_W-1:0]         qsum, qdsum;
  logic                              take;
  logic [ssr_pkg::SUM_W:0]           esum_wide;
  logic [ssr_pkg::SUM_W-1:0]         esum_add;
  logic [ssr_pkg::SQS_W:0]           qsum_wide, qdsum_wide;
  logic [ssr_pkg::SQS_W-1:0]         qsum_add, qdsum_add;

  // Excess return and its square for the incoming item.
  always_comb begin
    e_in  = {period_return[ssr_pkg::RET_W-1], period_return}
          - {risk_free_rate[ssr_pkg::RET_W-1], risk_free_rate};
    e_abs = e_in[ssr_pkg::EXC_W-1] ? -e_in : e_in;
    sq_in = e_abs[ssr_pkg::MAG_IN_W-1:0] * e_abs[ssr_pkg::MAG_IN_W-1:0];
  end

  // Saturating accumulation of the staged item.
  always_comb begin
    take      = a_valid && (cnt < ssr_pkg::CNT_W'(MAX_SERIES));
    esum_wide = {esum[ssr_pkg::SUM_W-1], esum}
              + {{(ssr_pkg::SUM_W + 1 - ssr_pkg::EXC_W){a_e[ssr_pkg::EXC_W-1]}}, a_e};
    if (esum_wide[ssr_pkg::SUM_W] != esum_wide[ssr_pkg::SUM_W-1]) begin
      esum_add = esum_wide[ssr_pkg::SUM_W] ? {1'b1, {(ssr_pkg::SUM_W-1){1'b0}}}
                                           : {1'b0, {(ssr_pkg::SUM_W-1){1'b1}}};
    end else begin
      esum_add = esum_wide[ssr_pkg::SUM_W-1:0];
    end
    qsum_wide  = {1'b0, qsum} + (ssr_pkg::SQS_W + 1)'(a_sq);
    qdsum_wide = {1'b0, qdsum} + (ssr_pkg::SQS_W + 1)'(a_sq);
    qsum_add   = qsum_wide[ssr_pkg::SQS_W] ? '1 : qsum_wide[ssr_pkg::SQS_W-1:0];
    qdsum_add  = qdsum_wide[ssr_pkg::SQS_W] ? '1 : qdsum_wide[ssr_pkg::SQS_W-1:0];

    snap.cnt   = take ? cnt + 1'b1 : cnt;
    snap.esum  = take ? $signed(esum_add) : esum;
    snap.qsum  = take ? qsum_add : qsum;
    snap.qdsum = (take && a_e[ssr_pkg::EXC_W-1]) ? qdsum_add : qdsum;
    snap.kcnt  = (take && a_e[ssr_pkg::EXC_W-1]) ? kcnt + 1'b1 : kcnt;
    push       = a_valid && a_last;
  end

  // Staging register and accumulators; a last item hands off and clears.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_last  <= 1'b0;
      cnt     <= '0;
      kcnt    <= '0;
      esum    <= '0;
      qsum    <= '0;
      qdsum   <= '0;
    end else begin
      a_valid <= accept;
      if (accept) begin
        a_last <= last_return;
        a_e    <= e_in;
        a_sq   <= sq_in;
      end
      if (push) begin
        cnt   <= '0;
        kcnt  <= '0;
        esum  <= '0;
        qsum  <= '0;
        qdsum <= '0;
      end else begin
        cnt   <= snap.cnt;
        kcnt  <= snap.kcnt;
        esum  <= snap.esum;
        qsum  <= snap.qsum;
        qdsum <= snap.qdsum;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ssr_rootdiv.sv =====
// Iterative unit: floor(sqrt(num / den)), saturated to 31 bits, by restoring division then bitwise root.
`default_nettype none
module ssr_rootdiv (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [ssr_pkg::NUM_W-1:0]   num,
  input  wire logic [ssr_pkg::DEN_W-1:0]   den,
  output logic                             done,
  output logic [ssr_pkg::MAG_W-1:0]        mag
);
  typedef enum logic [1:0] {RD_IDLE, RD_DIV, RD_ROOT} rd_state_t;

  rd_state_t                    st;
  logic [ssr_pkg::NUM_W-1:0]    r;
  logic [ssr_pkg::DSH_W-1:0]    dsh;
  logic [5:0]                   cnt;
  logic [ssr_pkg::QUO_W-1:0]    qv;
  logic [ssr_pkg::ROOT_W-1:0]   x, res, bitv;
  logic                         ge;
  logic [ssr_pkg::ROOT_W-1:0]   trial;
  logic                         fits;
  logic [ssr_pkg::ROOT_W-1:0]   res_n;

  // One quotient bit or one root bit per cycle.
  always_comb begin
    ge    = {{(ssr_pkg::DSH_W - ssr_pkg::NUM_W){1'b0}}, r} >= dsh;
    trial = res + bitv;
    fits  = x >= trial;
    res_n = fits ? (res >> 1) + bitv : res >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= RD_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        RD_IDLE: begin
          if (start) begin
            r   <= num;
            dsh <= {den, {ssr_pkg::QUO_W{1'b0}}};
            cnt <= 6'(ssr_pkg::QUO_W);
            st  <= RD_DIV;
          end
        end
        RD_DIV: begin
          if (ge) begin
            r <= r - dsh[ssr_pkg::NUM_W-1:0];
          end
          qv  <= {qv[ssr_pkg::QUO_W-2:0], ge};
          dsh <= dsh >> 1;
          cnt <= cnt - 1'b1;
          // A set top bit means the ratio exceeds the Q16.16 range.
          if (cnt == 6'(ssr_pkg::QUO_W) && ge) begin
            mag  <= '1;
            done <= 1'b1;
            st   <= RD_IDLE;
          end else if (cnt == '0) begin
            x    <= {2'b00, qv[ssr_pkg::QUO_W-2:0], ge};
            res  <= '0;
            bitv <= {2'b01, {(ssr_pkg::ROOT_W-2){1'b0}}};
            st   <= RD_ROOT;
          end
        end
        RD_ROOT: begin
          if (fits) begin
            x <= x - trial;
          end
          res  <= res_n;
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            mag  <= (res_n[ssr_pkg::ROOT_W-1:ssr_pkg::MAG_W] != '0) ? '1
                                                               : res_n[ssr_pkg::MAG_W-1:0];
            done <= 1'b1;
            st   <= RD_IDLE;
          end
        end
        default: st <= RD_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ssr_back.sv =====
// Back end: sequences the wide products and both ratio evaluations for one series.
`default_nettype none
module ssr_back (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 q_valid,
  input  wire ssr_pkg::snap_t                       q_data,
  output logic                                      pop,
  output logic                                      done,
  output logic signed [ssr_pkg::RATIO_W-1:0]        sharpe_ratio,
  output logic signed [ssr_pkg::RATIO_W-1:0]        sortino_ratio,
  output logic [ssr_pkg::CNT_W-1:0]                 series_length
);
  typedef enum logic [3:0] {
    B_IDLE, B_SQ, B_NQ, B_DEN1, B_NUM1, B_DIV1, B_TQ, B_DEN2, B_NUM2, B_DIV2
  } back_state_t;

  back_state_t                   st;
  logic                          neg;
  logic [ssr_pkg::CNT_W-1:0]     n, k;
  logic [ssr_pkg::SQS_W-1:0]     qs, qd;
  logic [ssr_pkg::S2_W-1:0]      s2;
  logic [ssr_pkg::DEN_W-1:0]     den;
  logic [ssr_pkg::NUM_W-1:0]     numr;
  logic [ssr_pkg::MUL_W-1:0]     mx, acc;
  logic [ssr_pkg::MULT_W-1:0]    mm;
  logic                          rd_start, rd_done;
  logic [ssr_pkg::MAG_W-1:0]     rd_mag;
  logic [ssr_pkg::SUM_W-1:0]     abs_s;
  logic                          mul_fin, sort_go;
  logic [ssr_pkg::S2_W-1:0]      prod81;
  logic signed [ssr_pkg::RATIO_W-1:0] ratio;

  always_comb begin
    pop     = (st == B_IDLE) && q_valid;
    abs_s   = q_data.esum[ssr_pkg::SUM_W-1] ? -q_data.esum : q_data.esum;
    mul_fin = (mm == '0);
    sort_go = (k != '0) && (qd != '0);
    prod81  = acc[ssr_pkg::S2_W-1:0];
    ratio   = neg ? -$signed({1'b0, rd_mag}) : $signed({1'b0, rd_mag});
  end

  ssr_rootdiv u_rootdiv (
    .clk   (clk),
    .rst   (rst),
    .start (rd_start),
    .num   (numr),
    .den   (den),
    .done  (rd_done),
    .mag   (rd_mag)
  );

  // Sequencer with a shift-and-add multiplier: one operand bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= B_IDLE;
      done     <= 1'b0;
      rd_start <= 1'b0;
    end else begin
      done     <= 1'b0;
      rd_start <= 1'b0;
      if (st != B_IDLE && st != B_DIV1 && st != B_DIV2 && !mul_fin) begin
        acc <= acc + (mm[0] ? mx : '0);
        mx  <= mx << 1;
        mm  <= mm >> 1;
      end else begin
        case (st)
          B_IDLE: begin
            if (q_valid) begin
              neg           <= q_data.esum[ssr_pkg::SUM_W-1];
              n             <= q_data.cnt;
              k             <= q_data.kcnt;
              qs            <= q_data.qsum;
              qd            <= q_data.qdsum;
              series_length <= q_data.cnt;
              if (abs_s == '0) begin
                sharpe_ratio  <= '0;
                sortino_ratio <= '0;
                done          <= 1'b1;
              end else begin
                mx  <= ssr_pkg::MUL_W'(abs_s);
                mm  <= abs_s;
                acc <= '0;
                st  <= B_SQ;
              end
            end
          end
          B_SQ: begin
            s2 <= prod81;
            if (n >= ssr_pkg::CNT_W'(2)) begin
              mx  <= ssr_pkg::MUL_W'(qs);
              mm  <= ssr_pkg::MULT_W'(n);
              acc <= '0;
              st  <= B_NQ;
            end else begin
              sharpe_ratio <= '0;
              if (sort_go) begin
                mx  <= ssr_pkg::MUL_W'(qd);
                mm  <= ssr_pkg::MULT_W'(n);
                acc <= '0;
                st  <= B_TQ;
              end else begin
                sortino_ratio <= '0;
                done          <= 1'b1;
                st            <= B_IDLE;
              end
            end
          end
          B_NQ: begin
            // Positive deviation only when n*Q exceeds S squared.
            if (prod81 > s2) begin
              mx  <= ssr_pkg::MUL_W'(prod81 - s2);
              mm  <= ssr_pkg::MULT_W'(n);
              acc <= '0;
              st  <= B_DEN1;
            end else begin
              sharpe_ratio <= '0;
              if (sort_go) begin
                mx  <= ssr_pkg::MUL_W'(qd);
                mm  <= ssr_pkg::MULT_W'(n);
                acc <= '0;
                st  <= B_TQ;
              end else begin
                sortino_ratio <= '0;
                done          <= 1'b1;
                st            <= B_IDLE;
              end
            end
          end
          B_DEN1: begin
            den <= acc[ssr_pkg::DEN_W-1:0];
            mx  <= ssr_pkg::MUL_W'(s2);
            mm  <= ssr_pkg::MULT_W'(n - 1'b1);
            acc <= '0;
            st  <= B_NUM1;
          end
          B_NUM1: begin
            numr     <= {acc[ssr_pkg::DEN_W-1:0], {ssr_pkg::FRAC_W{1'b0}}};
            rd_start <= 1'b1;
            st       <= B_DIV1;
          end
          B_DIV1: begin
            if (rd_done) begin
              sharpe_ratio <= ratio;
              if (sort_go) begin
                mx  <= ssr_pkg::MUL_W'(qd);
                mm  <= ssr_pkg::MULT_W'(n);
                acc <= '0;
                st  <= B_TQ;
              end else begin
                sortino_ratio <= '0;
                done          <= 1'b1;
                st            <= B_IDLE;
              end
            end
          end
          B_TQ: begin
            mx  <= ssr_pkg::MUL_W'(prod81);
            mm  <= ssr_pkg::MULT_W'(n);
            acc <= '0;
            st  <= B_DEN2;
          end
          B_DEN2: begin
            den <= acc[ssr_pkg::DEN_W-1:0];
            mx  <= ssr_pkg::MUL_W'(s2);
            mm  <= ssr_pkg::MULT_W'(k);
            acc <= '0;
            st  <= B_NUM2;
          end
          B_NUM2: begin
            numr     <= {acc[ssr_pkg::DEN_W-1:0], {ssr_pkg::FRAC_W{1'b0}}};
            rd_start <= 1'b1;
            st       <= B_DIV2;
          end
          B_DIV2: begin
            if (rd_done) begin
              sortino_ratio <= ratio;
              done          <= 1'b1;
              st            <= B_IDLE;
            end
          end
          default: st <= B_IDLE;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/sharpe_sortino_ratio.sv =====
// Top level of the Sharpe and Sortino ratio unit.
// Returns are taken one per cycle whenever busy is low; each item is folded into
// the running sums in the cycle after it is accepted. The item marked last hands its
// series totals to a one-entry queue, and busy stays high from that item until the
// back end has taken the totals, so a following series may start as soon as the
// previous one is handed off. The back end uses a shift-and-add multiplier (one
// operand bit per cycle, operands of up to 41 bits, up to seven products) and a
// shared iterative unit that runs a restoring division and then a bitwise square
// root for each ratio; when the mean excess is zero it skips both and reports zero
// ratios. The result appears on the output ports for one cycle with done high;
// the receiver cannot stall it.
`default_nettype none
module sharpe_sortino_ratio #(
  parameter int MAX_SERIES = 65536
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic signed [ssr_pkg::RET_W-1:0]    risk_free_rate,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [ssr_pkg::RET_W-1:0]    period_return,
  input  wire logic                                last_return,
  output logic                                     done,
  output logic signed [ssr_pkg::RATIO_W-1:0]       sharpe_ratio,
  output logic signed [ssr_pkg::RATIO_W-1:0]       sortino_ratio,
  output logic [ssr_pkg::CNT_W-1:0]                series_length
);
  logic signed [ssr_pkg::RET_W-1:0] rf;
  logic                             accept, push, pop, q_valid;
  ssr_pkg::snap_t                   snap, q_data;

  assign accept = start && !busy;
  // Hold off while totals wait in the queue or a last item is still being folded in.
  assign busy   = q_valid || push;

  // Risk-free rate register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rf <= '0;
    end else if (cfg_write) begin
      rf <= risk_free_rate;
    end
  end

  ssr_front #(.MAX_SERIES(MAX_SERIES)) u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .period_return  (period_return),
    .last_return    (last_return),
    .risk_free_rate (rf),
    .push           (push),
    .snap           (snap)
  );

  // One-entry queue of series totals between the front and back ends.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (push) begin
      q_valid <= 1'b1;
      q_data  <= snap;
    end else if (pop) begin
      q_valid <= 1'b0;
    end
  end

  ssr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .pop           (pop),
    .done          (done),
    .sharpe_ratio  (sharpe_ratio),
    .sortino_ratio (sortino_ratio),
    .series_length (series_length)
  );

  // A hand-off never lands on a full queue.
  a_push_empty: assert property (@(posedge clk) disable iff (rst) push |-> !q_valid)
    else $error("series totals pushed into a full queue");

  // Every strobed result carries fully defined values.
  a_done_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown({sharpe_ratio, sortino_ratio, series_length}))
    else $error("result strobed with undefined value");

  // Accepting a last item blocks the next item until its totals are handed off.
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && last_return) |=> busy)
    else $error("busy low right after a last item");
endmodule
`default_nettype wire

// ===== bench/sharpe_sortino_ratio_chk.sv =====
// Checker for the Sharpe/Sortino ratio unit: predicts each series result and compares it.
module sharpe_sortino_ratio_chk (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic signed [ssr_pkg::RET_W-1:0]  risk_free_rate,
  input  logic                              start,
  input  logic                              busy,
  input  logic signed [ssr_pkg::RET_W-1:0]  period_return,
  input  logic                              last_return,
  input  logic                              done,
  input  logic signed [ssr_pkg::RATIO_W-1:0] sharpe_ratio,
  input  logic signed [ssr_pkg::RATIO_W-1:0] sortino_ratio,
  input  logic [ssr_pkg::CNT_W-1:0]         series_length,
  output int                                errors,
  output int                                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SERIES_CAP = 65536;
  localparam longint SUM_HI = 64'sd1099511627775;
  localparam longint SUM_LO = -64'sd1099511627776;

  typedef struct packed {
    logic [31:0] sharpe;
    logic [31:0] sortino;
    logic [16:0] len;
  } ratio_rec_t;

  ratio_rec_t ratio_q[$];

  // Predicted series totals and the active risk-free rate.
  logic signed [23:0] rate_now;
  int unsigned        n_cnt;
  int unsigned        k_cnt;
  longint             ex_sum;
  logic [63:0]        sq_sum;
  logic [63:0]        dn_sum;

  // Floor of sqrt(num / den), saturated to 31 bits, with the sign applied.
  function automatic logic [31:0] root_of_ratio(logic [255:0] num, logic [255:0] den,
                                                bit neg);
    logic [255:0] q;
    logic [127:0] r;
    logic [127:0] trial;
    logic [31:0]  mag;
    if (num >= (den << 62)) begin
      mag = 32'h7FFF_FFFF;
    end else begin
      q = num / den;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
        trial = r | (128'd1 << b);
        if (trial * trial <= q[127:0]) r = trial;
      end
      mag = (r > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
    end
    return neg ? (32'd0 - mag) : mag;
  endfunction

  // Folds one return into the running sums, and builds the result on the last one.
  task automatic fold_return(logic signed [23:0] ret, bit fin);
    longint       e;
    logic [63:0]  sq;
    logic [64:0]  wide;
    ratio_rec_t   rec;
    longint       abs_s;
    logic [255:0] s2, nq, den, num, n_w;
    if (n_cnt < SERIES_CAP) begin
      e = longint'(ret) - longint'(rate_now);
      sq = (e < 0) ? 64'(-e) * 64'(-e) : 64'(e) * 64'(e);
      ex_sum = ex_sum + e;
      if (ex_sum > SUM_HI) ex_sum = SUM_HI;
      if (ex_sum < SUM_LO) ex_sum = SUM_LO;
      wide = {1'b0, sq_sum} + {1'b0, sq};
      sq_sum = wide[64] ? '1 : wide[63:0];
      if (e < 0) begin
        wide = {1'b0, dn_sum} + {1'b0, sq};
        dn_sum = wide[64] ? '1 : wide[63:0];
        k_cnt++;
      end
      n_cnt++;
    end
    if (!fin) return;
    rec.sharpe = '0;
    rec.sortino = '0;
    rec.len = 17'(n_cnt);
    abs_s = (ex_sum < 0) ? -ex_sum : ex_sum;
    if (abs_s != 0) begin
      n_w = 256'(n_cnt);
      s2 = 256'(abs_s) * 256'(abs_s);
      if (n_cnt >= 2) begin
        nq = n_w * 256'(sq_sum);
        if (nq > s2) begin
          den = n_w * (nq - s2);
          num = (s2 * 256'(n_cnt - 1)) << 32;
          rec.sharpe = root_of_ratio(num, den, ex_sum < 0);
        end
      end
      if (k_cnt != 0 && dn_sum != 0) begin
        den = n_w * n_w * 256'(dn_sum);
        num = (s2 * 256'(k_cnt)) << 32;
        rec.sortino = root_of_ratio(num, den, ex_sum < 0);
      end
    end
    ratio_q = {ratio_q, rec};
    n_cnt = 0;
    k_cnt = 0;
    ex_sum = 0;
    sq_sum = '0;
    dn_sum = '0;
  endtask

  // Compare each strobed result with the oldest prediction, then take new items.
  always @(posedge clk) begin
    ratio_rec_t want;
    if (rst) begin
      errors = 0;
      rate_now = '0;
      n_cnt = 0;
      k_cnt = 0;
      ex_sum = 0;
      sq_sum = '0;
      dn_sum = '0;
      ratio_q.delete();
    end else begin
      if (done) begin
        if (ratio_q.size() == 0) begin
          $display("%0t: result with none expected: sharpe %0d sortino %0d length %0d",
                   $time, sharpe_ratio, sortino_ratio, series_length);
          errors++;
        end else begin
          want = ratio_q.pop_front();
          if (sharpe_ratio !== want.sharpe) begin
            $display("%0t: sharpe_ratio expected %0d actual %0d", $time,
                     $signed(want.sharpe), sharpe_ratio);
            errors++;
          end
          if (sortino_ratio !== want.sortino) begin
            $display("%0t: sortino_ratio expected %0d actual %0d", $time,
                     $signed(want.sortino), sortino_ratio);
            errors++;
          end
          if (series_length !== want.len) begin
            $display("%0t: series_length expected %0d actual %0d", $time,
                     want.len, series_length);
            errors++;
          end
        end
      end
      if (start && !busy) fold_return(period_return, last_return);
      if (cfg_write) rate_now = risk_free_rate;
    end
    pending = ratio_q.size();
  end
endmodule

// ===== bench/sharpe_sortino_ratio_tb.sv =====
// Testbench top for the Sharpe/Sortino ratio unit: stimulus, rate changes and verdict.
module sharpe_sortino_ratio_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic signed [23:0] risk_free_rate;
  logic        start;
  logic        busy;
  logic signed [23:0] period_return;
  logic        last_return;
  logic        done;
  logic signed [31:0] sharpe_ratio;
  logic signed [31:0] sortino_ratio;
  logic [16:0] series_length;
  int          errors;
  int          pending;
  int          sent;
  int          burst_left;

  sharpe_sortino_ratio dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .risk_free_rate(risk_free_rate),
    .start(start), .busy(busy), .period_return(period_return),
    .last_return(last_return), .done(done), .sharpe_ratio(sharpe_ratio),
    .sortino_ratio(sortino_ratio), .series_length(series_length)
  );

  sharpe_sortino_ratio_chk chk (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .risk_free_rate(risk_free_rate),
    .start(start), .busy(busy), .period_return(period_return),
    .last_return(last_return), .done(done), .sharpe_ratio(sharpe_ratio),
    .sortino_ratio(sortino_ratio), .series_length(series_length),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Hands one return to the block and waits until it is taken.
  task automatic push_return(logic signed [23:0] ret, bit fin, bit paced);
    if (paced && burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
    end
    start = 1'b1;
    period_return = ret;
    last_return = fin;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 1'b0;
    if (burst_left > 0) burst_left--;
    sent++;
  endtask

  // Waits until the block is idle, then loads a new risk-free rate.
  task automatic load_rate(logic signed [23:0] rate);
    wait (pending == 0);
    repeat (20) @(negedge clk);
    cfg_write = 1'b1;
    risk_free_rate = rate;
    @(negedge clk);
    cfg_write = 1'b0;
    risk_free_rate = 24'($urandom);
  endtask

  // Draws a return: mostly near zero or near the rate, sometimes full range or extreme.
  function automatic logic signed [23:0] pick_return(logic signed [23:0] rate);
    case ($urandom_range(0, 4))
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(0, 8191)) - 4096);
      2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      default: return rate + 24'($signed($urandom_range(0, 65535)) - 32768);
    endcase
  endfunction

  // One random series of mostly short length.
  task automatic random_series(logic signed [23:0] rate);
    int len;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 40);
    for (int i = 0; i < len; i++) push_return(pick_return(rate), i == len - 1, 1'b1);
  endtask

  initial begin
    logic signed [23:0] rates [5];
    rst = 1'b1;
    cfg_write = 1'b0;
    risk_free_rate = '0;
    start = 1'b0;
    period_return = '0;
    last_return = 1'b0;
    sent = 0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: rate left at its reset value of zero.
    push_return(24'sd1000, 1'b1, 1'b0);             // one sample
    push_return(24'sd5000, 1'b0, 1'b0);             // zero deviation
    push_return(24'sd5000, 1'b1, 1'b0);
    push_return(24'sd3000, 1'b0, 1'b0);             // no downside
    push_return(24'sd9000, 1'b1, 1'b0);
    push_return(24'sd7000, 1'b0, 1'b0);             // zero mean excess
    push_return(-24'sd7000, 1'b1, 1'b0);
    push_return(24'sd100000, 1'b0, 1'b0);           // huge ratio, saturates
    push_return(24'sd100001, 1'b1, 1'b0);
    push_return(24'sh7FFFFF, 1'b0, 1'b0);           // field extremes
    push_return(24'sh800000, 1'b0, 1'b0);
    push_return(24'sh800000, 1'b0, 1'b0);
    push_return(-24'sd1, 1'b1, 1'b0);

    // Extreme rates, a random one, a fixed rate near 0.05 and another random one, each with random series.
    rates[0] = 24'sh800000;
    rates[1] = 24'sh7FFFFF;
    rates[2] = 24'($urandom);
    rates[3] = 24'sd52429;
    rates[4] = 24'($urandom);
    for (int p = 0; p < 5; p++) begin
      load_rate(rates[p]);
      push_return(24'sh7FFFFF, 1'b0, 1'b0);
      push_return(24'sh800000, 1'b1, 1'b0);
      sent = 0;
      while (sent < 210) random_series(rates[p]);
    end

    wait (pending == 0);
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("sharpe_sortino_ratio verification clean");
    end else begin
      $display("sharpe_sortino_ratio verification failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #60000000;
    $display("sharpe_sortino_ratio verification failed");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/ssr_pkg.sv
rtl/ssr_front.sv
rtl/ssr_rootdiv.sv
rtl/ssr_back.sv
rtl/sharpe_sortino_ratio.sv
bench/sharpe_sortino_ratio_chk.sv
bench/sharpe_sortino_ratio_tb.sv
